// File: rtl/cdi_pkg.sv
// Shared constants, types and cost tables of the disk inflation block.
`default_nettype none
package cdi_pkg;
  localparam int GridW = 64;
  localparam int GridH = 64;
  localparam int MaxRadius = 31;
  localparam int AddrW = $clog2(GridW * GridH);
  localparam int CellsN = GridW * GridH;
  localparam logic [7:0] NoInfo = 8'd255;
  localparam logic [1:0] FuncClear = 2'd0;
  localparam logic [1:0] FuncInflate = 2'd1;
  localparam logic [1:0] FuncRead = 2'd2;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;     // capture the input beat
    logic clr_wr;   // write NoInfo at the sweep address
    logic cost_go;  // start the cost unit for the current offset
    logic rd_cell;  // read grid at the current cell
    logic wr_cell;  // write merged cost back
    logic step;     // advance offset counters
    logic rd_req;   // read the requested cell
    logic out_load; // place the read result in the output register
  } cdi_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sweep_done;
    logic       scan_done;
    logic       in_disk;
    logic       cost_done;
  } cdi_sts_t;

  // round(exp(-k) * 2^30)
  function automatic logic [30:0] ek(input logic [2:0] k);
    case (k)
      3'd0: ek = 31'd1073741824;
      3'd1: ek = 31'd395007542;
      3'd2: ek = 31'd145315154;
      3'd3: ek = 31'd53458458;
      3'd4: ek = 31'd19666267;
      3'd5: ek = 31'd7234816;
      default: ek = 31'd2661540;
    endcase
  endfunction

  // floor(2^32 / n) for the Taylor term index n, 1 to 12
  function automatic logic [32:0] recip(input logic [3:0] n);
    case (n)
      4'd1: recip = 33'd4294967296;
      4'd2: recip = 33'd2147483648;
      4'd3: recip = 33'd1431655765;
      4'd4: recip = 33'd1073741824;
      4'd5: recip = 33'd858993459;
      4'd6: recip = 33'd715827882;
      4'd7: recip = 33'd613566756;
      4'd8: recip = 33'd536870912;
      4'd9: recip = 33'd477218588;
      4'd10: recip = 33'd429496729;
      4'd11: recip = 33'd390451572;
      default: recip = 33'd357913941;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/costmap_disk_inflation.sv
// Top level of the disk inflation cost grid.
// After reset a sweep writes 255 into all 4096 cells before the first beat is
// taken. A clear writes 255 into all cells again. A read registers the requested cell's
// cost as its result beat, and no new beat is taken until that result beat is accepted.
// An inflate visits (2r+1)^2 offsets; an offset off the disk or off the grid is only stepped
// past, a disk cell on the grid runs the cost unit (bitwise square root, then twelve Taylor
// terms, each a multiply, a reciprocal multiply for the divide, a correction and a sum), or
// skips the series when the scaled distance saturates the cost. The disk cells set the rate.
// One item is worked at a time.
`default_nettype none
module costmap_disk_inflation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func, center_x, center_y, radius_cells, inscribed_q, scale_q, max_cost
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cell_cost
  output logic [7:0]       m_tdata
);
  cdi_pkg::cdi_cmd_t cmd;
  cdi_pkg::cdi_sts_t sts;

  cdi_ctrl u_ctrl (.clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .sts, .cmd);
  cdi_datapath u_dp (.clk, .rst, .cmd, .sts, .in_data(s_tdata[64:0]), .cell_cost(m_tdata));
endmodule
`default_nettype wire

// File: rtl/cdi_cost.sv
// Iterative cost unit: square root, scaled distance, Taylor exponent, rounding.
`default_nettype none
module cdi_cost (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [10:0] d2,
  input  wire logic [13:0] inscribed_q,
  input  wire logic [15:0] scale_q,
  input  wire logic [7:0]  max_cost,
  output logic             done,
  output logic [7:0]       cost
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQRT = 4'd1, S_MUL = 4'd2, S_CLS = 4'd3,
    S_TM = 4'd4, S_TD = 4'd5, S_FIX = 4'd6, S_DIV = 4'd7, S_EK = 4'd8, S_RND = 4'd9,
    S_SCL = 4'd10, S_CLP = 4'd11;
  logic [3:0]  state;
  logic [26:0] sq_v;
  logic [26:0] sq_res;
  logic [26:0] sq_bit;
  logic signed [33:0] xq;
  logic        neg;
  logic [29:0] u;
  logic [60:0] prod;
  logic [30:0] term;
  logic signed [33:0] sum;
  logic [3:0]  n;
  logic [30:0] quo;
  logic [62:0] rq;
  logic [2:0]  kk;
  logic [31:0] e;
  logic [8:0]  raw;
  logic [28:0] sq_try;
  logic [30:0] dv_est;
  logic [34:0] dv_rem;
  logic [39:0] rnd;

  assign sq_try = {2'b0, sq_v} - ({2'b0, sq_res} + {2'b0, sq_bit});
  // quotient estimate from the reciprocal is low by at most one
  assign dv_est = rq[62:32];
  assign dv_rem = {4'd0, prod[60:30]} - {4'd0, dv_est} * {31'd0, n};
  assign rnd = ({8'd0, e} * 40'd252 + (40'd1 << 29)) >> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (go) begin
          sq_v <= {d2, 16'd0};
          sq_res <= '0;
          sq_bit <= 27'd1 << 26;
          state <= S_SQRT;
        end
        // one result bit per cycle
        S_SQRT: begin
          if (!sq_try[28]) begin
            sq_v <= sq_try[26:0];
            sq_res <= 27'((sq_res >> 1) + sq_bit);
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 27'd1) state <= S_MUL;
        end
        S_MUL: begin
          xq <= $signed({1'b0, scale_q}) * ($signed({4'b0, sq_res[13:0]}) -
                $signed({4'b0, inscribed_q}));
          state <= S_CLS;
        end
        S_CLS: begin
          term <= 31'd1 << 30;
          sum <= 34'sd1 << 30;
          n <= 4'd1;
          if (xq >= 34'sd458752) begin
            raw <= '0; state <= S_CLP;
          end else if (xq <= -34'sd65536) begin
            raw <= 9'd255; state <= S_CLP;
          end else if (xq >= 0) begin
            neg <= 1'b1; kk <= xq[18:16]; u <= {xq[15:0], 14'd0}; state <= S_TM;
          end else begin
            neg <= 1'b0; kk <= 3'd0; u <= {16'(-xq), 14'd0}; state <= S_TM;
          end
        end
        S_TM: begin
          prod <= term * u;
          state <= S_TD;
        end
        // divide (prod>>30) by n: reciprocal multiply, then one correction
        S_TD: begin
          rq <= prod[60:30] * cdi_pkg::recip(n);
          state <= S_FIX;
        end
        S_FIX: begin
          quo <= (dv_rem >= {31'd0, n}) ? dv_est + 31'd1 : dv_est;
          state <= S_DIV;
        end
        S_DIV: begin
          term <= quo;
          if (neg && n[0]) sum <= sum - $signed({3'b0, quo});
          else sum <= sum + $signed({3'b0, quo});
          if (n == 4'd12) state <= S_EK;
          else begin
            n <= n + 4'd1; state <= S_TM;
          end
        end
        S_EK: begin
          prod <= cdi_pkg::ek(kk) * sum[30:0];
          state <= S_RND;
        end
        // pick exp(-x) in Q.30, negative series sum counts as zero
        S_RND: begin
          if (sum < 0) e <= '0;
          else if (neg) e <= {1'b0, prod[60:30]};
          else e <= sum[31:0];
          state <= S_SCL;
        end
        S_SCL: begin
          raw <= (rnd > 40'd255) ? 9'd255 : rnd[8:0];
          state <= S_CLP;
        end
        S_CLP: begin
          cost <= ({1'b0, max_cost} < raw) ? max_cost : raw[7:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/cdi_datapath.sv
// Datapath: input capture, offset counters, cost unit, grid memory, output register.
`default_nettype none
module cdi_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cdi_pkg::cdi_cmd_t cmd,
  output cdi_pkg::cdi_sts_t     sts,
  input  wire logic [64:0]      in_data,
  output logic [7:0]            cell_cost
);
  logic [7:0] mem [cdi_pkg::CellsN];
  logic [1:0] func;
  logic signed [9:0] cx, cy;
  logic [4:0] r;
  logic [13:0] insc;
  logic [15:0] scl;
  logic [7:0] maxc;
  logic signed [6:0] oi, oj;
  logic [cdi_pkg::AddrW:0] swp;
  logic [7:0] rdat;
  logic cdone;
  logic [7:0] cval;
  logic signed [11:0] px, py;
  logic [10:0] d2w;
  logic on_grid;
  logic [cdi_pkg::AddrW-1:0] addr;
  logic [cdi_pkg::AddrW-1:0] req_addr;
  logic [cdi_pkg::AddrW-1:0] rd_addr;

  assign px = 12'(cx) + 12'(oi);
  assign py = 12'(cy) + 12'(oj);
  assign d2w = 11'(oi * oi) + 11'(oj * oj);
  assign on_grid = px >= 0 && px < cdi_pkg::GridW && py >= 0 && py < cdi_pkg::GridH;
  assign addr = cdi_pkg::AddrW'(py * cdi_pkg::GridW + px);
  assign req_addr = cdi_pkg::AddrW'(cy * cdi_pkg::GridW + cx);
  assign rd_addr = cmd.rd_req ? req_addr : addr;

  assign sts.func = func;
  assign sts.sweep_done = swp[cdi_pkg::AddrW];
  assign sts.scan_done = (oi == 7'($signed({1'b0, r}))) && (oj == 7'($signed({1'b0, r})));
  assign sts.in_disk = on_grid && d2w <= 11'(r * r);
  assign sts.cost_done = cdone;

  cdi_cost u_cost (
    .clk, .rst, .go(cmd.cost_go), .d2(d2w), .inscribed_q(insc),
    .scale_q(scl), .max_cost(maxc), .done(cdone), .cost(cval)
  );

  // capture beat, advance the sweep counter and step through offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      swp <= '0;
    end else if (cmd.load) begin
      func <= in_data[1:0];
      cx <= in_data[11:2];
      cy <= in_data[21:12];
      r <= (in_data[26:22] > 5'(cdi_pkg::MaxRadius)) ? 5'(cdi_pkg::MaxRadius) : in_data[26:22];
      insc <= in_data[40:27];
      scl <= in_data[56:41];
      maxc <= in_data[64:57];
      swp <= '0;
      oi <= -7'($signed({1'b0, (in_data[26:22] > 5'(cdi_pkg::MaxRadius)) ?
            5'(cdi_pkg::MaxRadius) : in_data[26:22]}));
      oj <= -7'($signed({1'b0, (in_data[26:22] > 5'(cdi_pkg::MaxRadius)) ?
            5'(cdi_pkg::MaxRadius) : in_data[26:22]}));
    end else begin
      if (cmd.clr_wr) swp <= swp + 1'b1;
      if (cmd.step) begin
        if (oj == 7'($signed({1'b0, r}))) begin
          oj <= -7'($signed({1'b0, r}));
          oi <= oi + 7'sd1;
        end else oj <= oj + 7'sd1;
      end
    end
  end

  // grid memory, one write port and one read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[swp[cdi_pkg::AddrW-1:0]] <= cdi_pkg::NoInfo;
    else if (cmd.wr_cell) begin
      if (rdat == cdi_pkg::NoInfo || cval > rdat) mem[addr] <= cval;
    end
    if (cmd.rd_cell || cmd.rd_req) rdat <= mem[rd_addr];
  end

  // hold the read result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_cost <= (cx >= 0 && cx < cdi_pkg::GridW && cy >= 0 && cy < cdi_pkg::GridH) ?
                   rdat : cdi_pkg::NoInfo;
    end
  end
endmodule
`default_nettype wire

// File: rtl/cdi_ctrl.sv
// Controller state machine sequencing clear, inflate and read items.
`default_nettype none
module cdi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire cdi_pkg::cdi_sts_t  sts,
  output cdi_pkg::cdi_cmd_t      cmd
);
  localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_DEC = 3'd2, S_CLR = 3'd3,
    S_VIS = 3'd4, S_WAIT = 3'd5, S_WR = 3'd6, S_RD = 3'd7;
  logic [2:0] state, state_next;
  logic out_next;

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_comb begin
    cmd = '0;
    state_next = state;
    out_next = m_tvalid && !m_tready;
    case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_done) begin
          cmd.clr_wr = 1'b0; state_next = S_IDLE;
        end
      end
      S_IDLE: if (s_tvalid && s_tready) begin
        cmd.load = 1'b1; state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.func == cdi_pkg::FuncClear) state_next = S_CLR;
        else if (sts.func == cdi_pkg::FuncInflate) state_next = S_VIS;
        else if (sts.func == cdi_pkg::FuncRead) begin
          cmd.rd_req = 1'b1; state_next = S_RD;
        end else state_next = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_wr = !sts.sweep_done;
        if (sts.sweep_done) state_next = S_IDLE;
      end
      S_VIS: begin
        if (sts.in_disk) begin
          cmd.cost_go = 1'b1; state_next = S_WAIT;
        end else begin
          cmd.step = 1'b1;
          if (sts.scan_done) state_next = S_IDLE;
        end
      end
      S_WAIT: if (sts.cost_done) begin
        cmd.rd_cell = 1'b1; state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_cell = 1'b1; cmd.step = 1'b1;
        state_next = sts.scan_done ? S_IDLE : S_VIS;
      end
      S_RD: begin
        cmd.out_load = 1'b1; out_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      m_tvalid <= out_next;
    end
  end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the disk inflation cost grid: directed and random beats.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FuncNop = 2'd3;
  localparam int ReadLatency = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;  // func, center_x, center_y, radius_cells, inscribed_q, scale_q, max_cost
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;  // cell_cost

  costmap_disk_inflation dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0] grid_shadow [cdi_pkg::CellsN];
  logic [7:0] cell_costs_due [$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int n_reads, n_inflates, n_clears, n_results;

  // Integer square root, bit by bit.
  function automatic longint unsigned root_q8(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 30;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Truncated degree-12 series of exp(+/-mag), Q.30 result.
  function automatic longint unsigned exp_series(input longint unsigned mag16, input bit neg);
    longint unsigned u, term;
    longint sum;
    u = mag16 << 14;
    term = 64'd1 << 30;
    sum = 64'sd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u) >> 30) / n;
      if (neg && (n % 2 == 1)) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  function automatic longint unsigned exp_whole(input int k);
    case (k)
      0: return 64'd1073741824;
      1: return 64'd395007542;
      2: return 64'd145315154;
      3: return 64'd53458458;
      4: return 64'd19666267;
      5: return 64'd7234816;
      default: return 64'd2661540;
    endcase
  endfunction

  // Decayed cost for one offset at squared distance d2.
  function automatic logic [7:0] decay_cost(input int d2, input int insc, input int scale,
                                             input int maxc);
    longint dq, x;
    longint unsigned e, raw;
    dq = longint'(root_q8(longint'(d2) << 16));
    x = longint'(scale) * (dq - longint'(insc));
    if (x >= 7 * 65536) raw = 0;
    else if (x <= -65536) raw = 255;
    else begin
      if (x >= 0) e = (exp_whole(int'(x >> 16)) * exp_series(x & 64'hFFFF, 1'b1)) >> 30;
      else e = exp_series(-x, 1'b0);
      raw = (252 * e + (64'd1 << 29)) >> 30;
      if (raw > 255) raw = 255;
    end
    if (raw > maxc) raw = maxc;
    return raw[7:0];
  endfunction

  // Apply one accepted beat to the shadow grid; queue the read answer.
  task automatic apply_beat(input logic [71:0] d);
    logic [1:0] fn;
    int cx, cy, r, insc, scale, maxc, x, y, idx;
    logic [7:0] c;
    fn = d[1:0];
    cx = $signed(d[11:2]);
    cy = $signed(d[21:12]);
    r = d[26:22];
    insc = d[40:27];
    scale = d[56:41];
    maxc = d[64:57];
    if (r > cdi_pkg::MaxRadius) r = cdi_pkg::MaxRadius;
    case (fn)
      cdi_pkg::FuncClear: begin
        foreach (grid_shadow[k]) grid_shadow[k] = cdi_pkg::NoInfo;
        n_clears++;
      end
      cdi_pkg::FuncInflate: begin
        n_inflates++;
        for (int i = -r; i <= r; i++)
          for (int j = -r; j <= r; j++) begin
            x = cx + i;
            y = cy + j;
            if (i * i + j * j > r * r) continue;
            if (x < 0 || x >= cdi_pkg::GridW || y < 0 || y >= cdi_pkg::GridH) continue;
            c = decay_cost(i * i + j * j, insc, scale, maxc);
            idx = y * cdi_pkg::GridW + x;
            if (grid_shadow[idx] == cdi_pkg::NoInfo || c > grid_shadow[idx])
              grid_shadow[idx] = c;
          end
      end
      cdi_pkg::FuncRead: begin
        n_reads++;
        if (cx >= 0 && cx < cdi_pkg::GridW && cy >= 0 && cy < cdi_pkg::GridH)
          cell_costs_due.push_back(grid_shadow[cy * cdi_pkg::GridW + cx]);
        else
          cell_costs_due.push_back(cdi_pkg::NoInfo);
      end
      default: ;
    endcase
  endtask

  // Pack the fields from the lowest bit up, zero pad to 72 bits.
  function automatic logic [71:0] pack_beat(input logic [1:0] fn, input int cx, input int cy,
                                            input int r, input int insc, input int scale,
                                            input int maxc);
    logic [9:0] px, py;
    px = cx[9:0];
    py = cy[9:0];
    return {7'd0, maxc[7:0], scale[15:0], insc[13:0], r[4:0], py, px, fn};
  endfunction

  // Send one beat, sometimes after random leading idle cycles; otherwise valid stays up between beats.
  task automatic send_beat(input logic [71:0] d);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    apply_beat(d);
  endtask

  // Hold off until every read answer is back, then let the block settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (cell_costs_due.size() != 0) @(posedge clk);
    repeat (ReadLatency) @(posedge clk);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result beat with the oldest pending answer.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (cell_costs_due.size() == 0) begin
        $error("unexpected result beat: cell_cost=%0d", m_tdata);
        errors++;
      end else begin
        logic [7:0] want;
        want = cell_costs_due.pop_front();
        if (m_tdata !== want) begin
          $error("cell_cost mismatch: expected %0d, actual %0d", want, m_tdata);
          errors++;
        end
      end
    end
  end

  task automatic read_cell(input int cx, input int cy);
    send_beat(pack_beat(cdi_pkg::FuncRead, cx, cy, 0, 0, 0, 0));
  endtask

  // Field extremes, every function, and the listed corner cases.
  task automatic test_directed();
    read_cell(0, 0);
    read_cell(63, 63);
    read_cell(-512, 511);
    read_cell(511, -512);
    read_cell(64, 5);
    send_beat(pack_beat(cdi_pkg::FuncInflate, 10, 10, 0, 0, 0, 254));
    read_cell(10, 10);
    // max_cost above 254 lets a cost of 255 land in the grid
    send_beat(pack_beat(cdi_pkg::FuncInflate, 10, 10, 2, 16383, 65535, 255));
    read_cell(11, 10);
    send_beat(pack_beat(cdi_pkg::FuncInflate, 0, 63, 3, 0, 65535, 0));
    read_cell(0, 62);
    send_beat(pack_beat(cdi_pkg::FuncInflate, 40, 40, 3, 256, 300, 100));
    read_cell(41, 41);
    read_cell(40, 43);
    // largest radius with center off the grid: only a corner of the disk lands
    send_beat(pack_beat(cdi_pkg::FuncInflate, -20, -20, 31, 5000, 40, 200));
    read_cell(0, 3);
    send_beat(pack_beat(FuncNop, 511, -1, 31, 16383, 65535, 255));
    send_beat(pack_beat(cdi_pkg::FuncClear, -1, -1, 31, 16383, 65535, 255));
    read_cell(10, 10);
    read_cell(0, 63);
    drain_results();
  endtask

  int hot_x, hot_y;

  // Random mix weighted toward inflate-then-read around a recent center.
  task automatic test_random(input int count);
    int sel, cx, cy, r, insc, scale, maxc;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        if ($urandom_range(9) == 0) begin
          cx = $signed(10'($urandom));
          cy = $signed(10'($urandom));
        end else begin
          cx = $urandom_range(cdi_pkg::GridW + 7) - 4;
          cy = $urandom_range(cdi_pkg::GridH + 7) - 4;
        end
        r = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(3);
        if (r > 3 && $urandom_range(1)) begin
          cx = cx - 2 * cdi_pkg::GridW;
        end
        insc = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(1024);
        scale = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1024);
        maxc = $urandom_range(255);
        hot_x = cx;
        hot_y = cy;
        send_beat(pack_beat(cdi_pkg::FuncInflate, cx, cy, r, insc, scale, maxc));
      end else if (sel < 85) begin
        if ($urandom_range(9) == 0) begin
          cx = $signed(10'($urandom));
          cy = $signed(10'($urandom));
        end else begin
          cx = hot_x + $urandom_range(6) - 3;
          cy = hot_y + $urandom_range(6) - 3;
        end
        send_beat(pack_beat(cdi_pkg::FuncRead, cx, cy, $urandom_range(31),
                            $urandom_range(16383), $urandom_range(65535),
                            $urandom_range(255)));
      end else if (sel < 92) begin
        send_beat(pack_beat(FuncNop, $signed(10'($urandom)), $signed(10'($urandom)),
                            $urandom_range(31), $urandom_range(16383),
                            $urandom_range(65535), $urandom_range(255)));
      end else begin
        send_beat(pack_beat(cdi_pkg::FuncClear, $signed(10'($urandom)), 0, 0, 0, 0, 0));
      end
    end
    drain_results();
  endtask

  initial begin
    errors = 0;
    n_reads = 0;
    n_inflates = 0;
    n_clears = 0;
    n_results = 0;
    hot_x = 20;
    hot_y = 20;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (grid_shadow[k]) grid_shadow[k] = cdi_pkg::NoInfo;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    // no idling, sender gaps, receiver stalls, both
    test_random(45);
    send_idle_pct = 52;
    test_random(40);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_random(40);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    test_random(45);

    repeat (ReadLatency) @(posedge clk);
    $display("covered %0d reads, %0d inflates, %0d clears; %0d result beats checked",
             n_reads, n_inflates, n_clears, n_results);
    $display("idle phases: none, sender gaps, receiver stalls, mixed");
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #80_000_000;
    $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/cdi_pkg.sv
rtl/cdi_cost.sv
rtl/cdi_datapath.sv
rtl/cdi_ctrl.sv
rtl/costmap_disk_inflation.sv
tb/tb_top.sv
